[hw/rtl/lcd_pixel_shadow_writer_unit_assert.svh]
// ----------------------------------------------------------------------------
// lcd pixel shadow writer assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LCD_PIXEL_SHADOW_WRITER_UNIT_ASSERT_SVH
`define LCD_PIXEL_SHADOW_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define LCDPSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCDPSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcdpsw_pkg.sv]
// ----------------------------------------------------------------------------
// lcdpsw_pkg
// shared types and constants of the lcd pixel shadow writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdpsw_pkg;

    localparam int BYTE_W        = 8;
    localparam int BIT_SEL_W     = 3;
    localparam int ROWS_PER_BANK = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_CMD_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BANK_CMD_BASE   = 2'd1;

    localparam logic [BYTE_W-1:0] COLUMN_CMD_BASE_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] BANK_CMD_BASE_RESET   = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] column_cmd_base;
        logic [BYTE_W-1:0] bank_cmd_base;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MERGE,
        B_COL,
        B_BANK,
        B_DATA
    } back_state_t;

endpackage

[hw/rtl/lcdpsw_pixel_if.sv]
// ----------------------------------------------------------------------------
// lcdpsw_pixel_if
// pixel request channel: one coordinate pair per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcdpsw_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[hw/rtl/lcdpsw_lcd_if.sv]
// ----------------------------------------------------------------------------
// lcdpsw_lcd_if
// lcd write channel: one command or data byte per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcdpsw_lcd_if;
    logic       valid;
    logic       ready;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
    logic       rejected;

    modport source (output valid, output lcd_byte, output is_data, output last,
                    output rejected, input ready);
    modport sink   (input valid, input lcd_byte, input is_data, input last,
                    input rejected, output ready);
endinterface

[hw/rtl/lcdpsw_fifo.sv]
// ----------------------------------------------------------------------------
// lcdpsw_fifo
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdpsw_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/lcdpsw_front.sv]
// ----------------------------------------------------------------------------
// lcdpsw_front
// takes pixel requests, checks the panel bounds, forms bank and store address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdpsw_front
    import lcdpsw_pkg::*;
#(
    parameter int COLUMNS = 84,
    parameter int ROWS    = 48
) (
    lcdpsw_pixel_if.sink pixel,
    input  back_status_t status,
    input  logic         q_full,
    output logic         push,
    output logic         item_rejected,
    output logic [BYTE_W-1:0] item_x,
    output logic [((((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK) > 1) ?
                   $clog2((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK) : 1)-1:0] item_bank,
    output logic [BIT_SEL_W-1:0] item_bit,
    output logic [$clog2(COLUMNS * ((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK))-1:0]
                   item_addr
);

    localparam int BANKS  = (ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK;
    localparam int DEPTH  = COLUMNS * BANKS;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);

    logic              in_panel;
    logic [COL_W-1:0]  col;

    assign pixel.ready = !q_full && !status.clearing;
    assign push        = pixel.valid && pixel.ready;

    // bounds check against the panel size
    assign in_panel = (pixel.pixel_x < BYTE_W'(COLUMNS)) && (pixel.pixel_y < BYTE_W'(ROWS));
    assign col      = pixel.pixel_x[COL_W-1:0];

    assign item_rejected = !in_panel;
    assign item_x        = pixel.pixel_x;
    assign item_bank     = pixel.pixel_y[BIT_SEL_W +: BANK_W];
    assign item_bit      = pixel.pixel_y[BIT_SEL_W-1:0];
    // column-major layout, one byte per bank of a column
    assign item_addr     = ADDR_W'(int'(col) * BANKS + int'(item_bank));

endmodule

[hw/rtl/lcdpsw_back.sv]
// ----------------------------------------------------------------------------
// lcdpsw_back
// shadow store read-modify-write and the lcd byte sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdpsw_back
    import lcdpsw_pkg::*;
#(
    parameter int COLUMNS = 84,
    parameter int ROWS    = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic                 head_rejected,
    input  logic [BYTE_W-1:0]    head_x,
    input  logic [((((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK) > 1) ?
                   $clog2((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK) : 1)-1:0] head_bank,
    input  logic [BIT_SEL_W-1:0] head_bit,
    input  logic [$clog2(COLUMNS * ((ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK))-1:0]
                   head_addr,
    output back_status_t         status,
    lcdpsw_lcd_if.source         lcd
);

    localparam int BANKS  = (ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK;
    localparam int DEPTH  = COLUMNS * BANKS;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [BYTE_W-1:0] cur_x_reg;
    logic [BANK_W-1:0] cur_bank_reg;
    logic [BIT_SEL_W-1:0] cur_bit_reg;
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] mem [DEPTH];

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_is_data_reg;
    logic              out_last_reg;
    logic              out_rejected_reg;

    logic              load_ok;
    logic              load;
    logic [BYTE_W-1:0] res_byte;
    logic              res_is_data;
    logic              res_last;
    logic              res_rejected;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] merged;
    logic              clear_done;

    assign load_ok    = !out_valid_reg || lcd.ready;
    assign merged     = rdata_reg | (8'b1 << cur_bit_reg);
    assign clear_done = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign status.clearing = (state_reg == B_CLEAR);

    assign lcd.valid    = out_valid_reg;
    assign lcd.lcd_byte = out_byte_reg;
    assign lcd.is_data  = out_is_data_reg;
    assign lcd.last     = out_last_reg;
    assign lcd.rejected = out_rejected_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_pop && !head_rejected)
                begin
                    state_next = B_MERGE;
                end
            end
            B_MERGE:
            begin
                state_next = load_ok ? B_BANK : B_COL;
            end
            B_COL:
            begin
                if (load_ok)
                begin
                    state_next = B_BANK;
                end
            end
            B_BANK:
            begin
                if (load_ok)
                begin
                    state_next = B_DATA;
                end
            end
            B_DATA:
            begin
                if (load_ok)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop        = 1'b0;
        load         = 1'b0;
        res_byte     = cfg.column_cmd_base | cur_x_reg;
        res_is_data  = 1'b0;
        res_last     = 1'b0;
        res_rejected = 1'b0;
        mem_we       = 1'b0;
        wr_addr      = cur_addr_reg;
        wdata        = merged;
        case (state_reg)
            B_CLEAR:
            begin
                mem_we  = 1'b1;
                wr_addr = clr_cnt_reg;
                wdata   = '0;
            end
            B_IDLE:
            begin
                // an out-of-panel pixel needs the output register at once
                q_pop = !q_empty && (!head_rejected || load_ok);
                if (q_pop && head_rejected)
                begin
                    load         = 1'b1;
                    res_byte     = '0;
                    res_last     = 1'b1;
                    res_rejected = 1'b1;
                end
            end
            B_MERGE:
            begin
                mem_we = 1'b1;
                load   = load_ok;
            end
            B_COL:
            begin
                load = load_ok;
            end
            B_BANK:
            begin
                load     = load_ok;
                res_byte = cfg.bank_cmd_base | BYTE_W'(cur_bank_reg);
            end
            B_DATA:
            begin
                load        = load_ok;
                res_byte    = data_reg;
                res_is_data = 1'b1;
                res_last    = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (lcd.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_x_reg    <= head_x;
            cur_bank_reg <= head_bank;
            cur_bit_reg  <= head_bit;
            cur_addr_reg <= head_addr;
        end
        if (state_reg == B_MERGE)
        begin
            data_reg <= merged;
        end
        if (load)
        begin
            out_byte_reg     <= res_byte;
            out_is_data_reg  <= res_is_data;
            out_last_reg     <= res_last;
            out_rejected_reg <= res_rejected;
        end
    end

    // shadow store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wdata;
        end
        rdata_reg <= mem[head_addr];
    end

endmodule

[hw/rtl/lcd_pixel_shadow_writer_unit.sv]
// ----------------------------------------------------------------------------
// lcd_pixel_shadow_writer_unit
// sets single pixels in a banked shadow frame buffer and emits lcd writes
// ----------------------------------------------------------------------------
//
//  port    dir   role    payload
//  pixel   in    sink    pixel_x, pixel_y
//  lcd     out   source  lcd_byte, is_data, last, rejected
//  cfg_*   in    write   cfg_index, cfg_data (no read-back)
//
//  an in-panel pixel runs through the back part as a registered shadow store
//  read, then a merge state that writes the store and issues the column
//  command once the output is free, then the bank command and the data byte;
//  a rejected pixel leaves the queue only when the output can take it
//  after reset a clearing pass zeroes all COLUMNS * ceil(ROWS / 8) store
//  bytes (504 by default); no pixel request is taken meanwhile
//  a two-entry queue decouples the front; lcd stalls hold the output register
//
`timescale 1ns / 1ps

`include "lcd_pixel_shadow_writer_unit_assert.svh"

module lcd_pixel_shadow_writer_unit
    import lcdpsw_pkg::*;
#(
    parameter int COLUMNS = 84,
    parameter int ROWS    = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lcdpsw_pixel_if.sink           pixel,
    lcdpsw_lcd_if.source           lcd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    localparam int BANKS  = (ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK;
    localparam int DEPTH  = COLUMNS * BANKS;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ITEM_W = 1 + BYTE_W + BANK_W + BIT_SEL_W + ADDR_W;
    localparam int Q_DEPTH = 2;

    // configuration registers
    cfg_t cfg_reg;

    // front to queue
    logic                 push;
    logic                 item_rejected;
    logic [BYTE_W-1:0]    item_x;
    logic [BANK_W-1:0]    item_bank;
    logic [BIT_SEL_W-1:0] item_bit;
    logic [ADDR_W-1:0]    item_addr;

    // queue to back
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic [ITEM_W-1:0]    q_head;
    logic                 head_rejected;
    logic [BYTE_W-1:0]    head_x;
    logic [BANK_W-1:0]    head_bank;
    logic [BIT_SEL_W-1:0] head_bit;
    logic [ADDR_W-1:0]    head_addr;

    back_status_t status;

    // register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_cmd_base <= COLUMN_CMD_BASE_RESET;
            cfg_reg.bank_cmd_base   <= BANK_CMD_BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_CMD_BASE: cfg_reg.column_cmd_base <= cfg_data;
                REG_BANK_CMD_BASE:   cfg_reg.bank_cmd_base   <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // front: bounds check and address forming
    lcdpsw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .pixel         (pixel),
        .status        (status),
        .q_full        (q_full),
        .push          (push),
        .item_rejected (item_rejected),
        .item_x        (item_x),
        .item_bank     (item_bank),
        .item_bit      (item_bit),
        .item_addr     (item_addr)
    );

    // classified requests wait here for the back part
    lcdpsw_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({item_rejected, item_x, item_bank, item_bit, item_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    assign {head_rejected, head_x, head_bank, head_bit, head_addr} = q_head;

    // back: shadow store update and byte sequencing
    lcdpsw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .head_rejected (head_rejected),
        .head_x        (head_x),
        .head_bank     (head_bank),
        .head_bit      (head_bit),
        .head_addr     (head_addr),
        .status        (status),
        .lcd           (lcd)
    );

    // no pixel request is taken while the store is being cleared
    `LCDPSW_ASSERT_NOW(a_no_accept_in_clear, pixel.valid && pixel.ready, !status.clearing, "pixel request taken during clear")
    // the store clear never overlaps an lcd write
    `LCDPSW_ASSERT_NOW(a_no_output_in_clear, status.clearing, !lcd.valid, "lcd write during clear")
    // a rejected result is a lone command-marked closing byte
    `LCDPSW_ASSERT_NOW(a_reject_shape, lcd.valid && lcd.rejected, lcd.last && !lcd.is_data && (lcd.lcd_byte == '0), "bad rejected result")
    // the queue is never popped while empty
    `LCDPSW_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
    // once cleared, the store never clears again until reset
    `LCDPSW_ASSERT_NEXT(a_clear_once, !status.clearing, !status.clearing, "clear restarted")

endmodule

[tb/sv/tb_lcd_pixel_shadow_writer_unit.sv]
// ----------------------------------------------------------------------------
// tb_lcd_pixel_shadow_writer_unit
// self-checking bench for the lcd pixel shadow writer: a directed table of
// pixel requests, then random pixels under several command base settings,
// with every lcd write compared against typed rows or a local shadow frame buffer model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_pixel_shadow_writer_unit;
    import lcdpsw_pkg::*;

    // panel geometry, kept equal to the parameters handed to the dut
    localparam int PANEL_COLS  = 84;
    localparam int PANEL_ROWS  = 48;
    localparam int BANK_COUNT  = (PANEL_ROWS + 7) / 8;
    localparam int SHADOW_SIZE = PANEL_COLS * BANK_COUNT;

    // register indexes past the two real ones; writes there must do nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    localparam int RANDOM_PHASES    = 5;
    localparam int PIXELS_PER_PHASE = 26;
    // worst case is far below this: the clearing pass plus ~150 requests,
    // each with up to three writes held by lcd stalls and a request gap
    localparam int CYCLE_LIMIT      = 200000;

    // one lcd write as seen on the output channel
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
        logic       rejected;
    } lcd_write_t;

    // directed row: coordinates, and for rows whose outcome is obvious the
    // writes typed in by hand (off-panel flag, column, bank and data bytes)
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       typed;
        logic       off_panel;
        logic [7:0] col_byte;
        logic [7:0] bank_byte;
        logic [7:0] data_byte;
    } pixel_row_t;

    localparam int ROW_COUNT = 22;

    // the first rows run with the reset command bases 0x80 and 0x40
    pixel_row_t pixel_rows [0:ROW_COUNT-1] = '{
        '{8'd0,   8'd0,   1'b1, 1'b0, 8'h80, 8'h40, 8'h01},  // origin
        '{8'd83,  8'd47,  1'b1, 1'b0, 8'hD3, 8'h45, 8'h80},  // far corner
        '{8'd84,  8'd0,   1'b1, 1'b1, 8'h00, 8'h00, 8'h00},  // one column past
        '{8'd0,   8'd48,  1'b1, 1'b1, 8'h00, 8'h00, 8'h00},  // one row past
        '{8'd255, 8'd255, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd255, 8'd0,   1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd0,   8'd255, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd0,   8'd7,   1'b1, 1'b0, 8'h80, 8'h40, 8'h81},  // merges into origin byte
        '{8'd83,  8'd40,  1'b1, 1'b0, 8'hD3, 8'h45, 8'h81},  // merges into corner byte
        '{8'd0,   8'd8,   1'b1, 1'b0, 8'h80, 8'h41, 8'h01},  // first row of bank 1
        '{8'd83,  8'd48,  1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd84,  8'd47,  1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd170, 8'd85,  1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd85,  8'd170, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd1,   8'd2,   1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd42,  8'd24,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd42,  8'd24,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},  // same pixel twice
        '{8'd42,  8'd31,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd64,  8'd16,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd31,  8'd33,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd83,  8'd0,   1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd0,   8'd47,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    lcdpsw_pixel_if pixel_ch ();
    lcdpsw_lcd_if   lcd_ch ();

    lcd_pixel_shadow_writer_unit #(
        .COLUMNS (PANEL_COLS),
        .ROWS    (PANEL_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .lcd       (lcd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the shadow frame buffer and the two command bases
    logic [7:0] shadow_bytes [0:SHADOW_SIZE-1];
    logic [7:0] column_base;
    logic [7:0] bank_base;

    // writes of the latest pixel, and the writes still owed by the dut
    lcd_write_t fresh_writes[$];
    lcd_write_t owed_writes[$];
    lcd_write_t oldest_write;

    int  fault_count;
    int  cycle_count;
    bit  source_steady;
    bit  sink_steady;
    int  stall_left;

    // ------------------------------------------------------------------
    // clock, reset and run watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles, %0d writes still owed",
                     $realtime, cycle_count, owed_writes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pixel model: sets one bit in the shadow copy and lists the writes
    // ------------------------------------------------------------------
    function automatic void shade_pixel(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] bank;
        int         addr;
        fresh_writes.delete();
        if (x >= PANEL_COLS || y >= PANEL_ROWS)
        begin
            // off panel: single rejected write, store untouched
            fresh_writes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
            return;
        end
        bank = y >> 3;
        addr = int'(x) * BANK_COUNT + int'(bank);
        shadow_bytes[addr] = shadow_bytes[addr] | (8'h01 << y[2:0]);
        fresh_writes.push_back('{column_base | x, 1'b0, 1'b0, 1'b0});
        fresh_writes.push_back('{bank_base | bank, 1'b0, 1'b0, 1'b0});
        fresh_writes.push_back('{shadow_bytes[addr], 1'b1, 1'b1, 1'b0});
    endfunction

    function automatic void owe_fresh_writes();
        foreach (fresh_writes[i])
            owed_writes.push_back(fresh_writes[i]);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(12, 30);
    endfunction

    // ------------------------------------------------------------------
    // request driver: inputs change on the falling edge only
    // ------------------------------------------------------------------

    // returns at the rising edge where the request was taken; valid stays
    // high so a back-to-back request needs no drop in between
    task automatic push_pixel(input logic [7:0] x, input logic [7:0] y);
        int gap;
        gap = 0;
        if (!source_steady && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid   = 1'b1;
        pixel_ch.pixel_x = x;
        pixel_ch.pixel_y = y;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        pixel_ch.valid = 1'b0;
        cfg_we         = 1'b1;
        cfg_index      = idx;
        cfg_data       = value;
        @(negedge clk);
        cfg_we = 1'b0;
        // unknown indexes fall through and change nothing
        case (idx)
            REG_COLUMN_CMD_BASE: column_base = value;
            REG_BANK_CMD_BASE:   bank_base   = value;
            default: ;
        endcase
    endtask

    // drop valid, hold off the sender until every owed write is out
    task automatic wait_until_idle();
        @(negedge clk);
        pixel_ch.valid = 1'b0;
        while (owed_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // random pixel: mostly in the panel, some crowded into a few columns so
    // bytes fill up, some off panel on either axis or anywhere at all
    task automatic random_pixel();
        logic [7:0] x;
        logic [7:0] y;
        int         mix;
        mix = $urandom_range(0, 9);
        case (mix)
            0:
            begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
            end
            1:
            begin
                x = 8'($urandom_range(PANEL_COLS, 255));
                y = 8'($urandom_range(0, 255));
            end
            2:
            begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(PANEL_ROWS, 255));
            end
            3, 4:
            begin
                x = 8'($urandom_range(0, 3));
                y = 8'($urandom_range(0, PANEL_ROWS - 1));
            end
            default:
            begin
                x = 8'($urandom_range(0, PANEL_COLS - 1));
                y = 8'($urandom_range(0, PANEL_ROWS - 1));
            end
        endcase
        push_pixel(x, y);
        shade_pixel(x, y);
        owe_fresh_writes();
    endtask

    // ------------------------------------------------------------------
    // lcd side: ready with random stalls, stall-free stretches per phase
    // ------------------------------------------------------------------
    initial
    begin
        lcd_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                lcd_ch.ready = 1'b0;
                stall_left   = stall_left - 1;
            end
            else
            begin
                lcd_ch.ready = 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // write checker: every taken lcd write against the oldest owed one
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t lcd %s mismatch: expected %h, actual %h",
                     $realtime, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && lcd_ch.valid && lcd_ch.ready)
        begin
            if (owed_writes.size() == 0)
            begin
                $display("%0t unexpected lcd write: expected none, actual byte %h",
                         $realtime, lcd_ch.lcd_byte);
                fault_count++;
            end
            else
            begin
                oldest_write = owed_writes.pop_front();
                check_field("lcd_byte", oldest_write.lcd_byte, lcd_ch.lcd_byte);
                check_field("is_data", 8'(oldest_write.is_data), 8'(lcd_ch.is_data));
                check_field("last", 8'(oldest_write.last), 8'(lcd_ch.last));
                check_field("rejected", 8'(oldest_write.rejected), 8'(lcd_ch.rejected));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // every dut input known from time zero
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_COLUMN_CMD_BASE;
        cfg_data         = 8'h00;
        pixel_ch.valid   = 1'b0;
        pixel_ch.pixel_x = 8'h00;
        pixel_ch.pixel_y = 8'h00;
        fault_count      = 0;
        cycle_count      = 0;
        source_steady    = 1'b1;
        sink_steady      = 1'b1;
        column_base      = COLUMN_CMD_BASE_RESET;
        bank_base        = BANK_CMD_BASE_RESET;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = 8'h00;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed table at the reset command bases; the clearing pass after
        // reset simply holds off the first request
        foreach (pixel_rows[i])
        begin
            push_pixel(pixel_rows[i].x, pixel_rows[i].y);
            shade_pixel(pixel_rows[i].x, pixel_rows[i].y);
            if (pixel_rows[i].typed)
            begin
                // the model still runs so the shadow copy stays current
                fresh_writes.delete();
                if (pixel_rows[i].off_panel)
                    fresh_writes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                else
                begin
                    fresh_writes.push_back('{pixel_rows[i].col_byte, 1'b0, 1'b0, 1'b0});
                    fresh_writes.push_back('{pixel_rows[i].bank_byte, 1'b0, 1'b0, 1'b0});
                    fresh_writes.push_back('{pixel_rows[i].data_byte, 1'b1, 1'b1, 1'b0});
                end
            end
            owe_fresh_writes();
            // halfway through, stall the sender until the lcd side catches up
            if (i == ROW_COUNT / 2)
                wait_until_idle();
        end
        wait_until_idle();

        // random phases, each under its own command bases
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_COLUMN_CMD_BASE, 8'h00);
                    write_reg(REG_BANK_CMD_BASE, 8'h00);
                end
                1:
                begin
                    write_reg(REG_COLUMN_CMD_BASE, 8'hFF);
                    write_reg(REG_BANK_CMD_BASE, 8'hFF);
                end
                2:
                begin
                    write_reg(REG_COLUMN_CMD_BASE, 8'h55);
                    write_reg(REG_BANK_CMD_BASE, 8'hAA);
                end
                3:
                begin
                    write_reg(REG_COLUMN_CMD_BASE, 8'($urandom_range(0, 255)));
                    write_reg(REG_BANK_CMD_BASE, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    // back to reset values, then writes to unknown indexes
                    write_reg(REG_COLUMN_CMD_BASE, COLUMN_CMD_BASE_RESET);
                    write_reg(REG_BANK_CMD_BASE, BANK_CMD_BASE_RESET);
                    write_reg(REG_UNUSED_A, 8'($urandom_range(0, 255)));
                    write_reg(REG_UNUSED_B, 8'($urandom_range(0, 255)));
                end
            endcase

            // first phase runs at full rate, later ones idle at random
            source_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
            sink_steady   = (phase == 0) || ($urandom_range(0, 3) == 0);

            repeat (PIXELS_PER_PHASE)
                random_pixel();
            wait_until_idle();
        end

        @(negedge clk);
        pixel_ch.valid = 1'b0;
        wait_until_idle();
        repeat (12) @(posedge clk);

        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lcdpsw_pkg.sv
hw/rtl/lcdpsw_pixel_if.sv
hw/rtl/lcdpsw_lcd_if.sv
hw/rtl/lcdpsw_fifo.sv
hw/rtl/lcdpsw_front.sv
hw/rtl/lcdpsw_back.sv
hw/rtl/lcd_pixel_shadow_writer_unit.sv
tb/sv/tb_lcd_pixel_shadow_writer_unit.sv
